// ----- rtl/dns_pkg.sv -----
// Shared types and constants for the directional nearest-select block.
// Used by the front, queue, back and top-level files; no dependencies.
`default_nettype none
package dns_pkg;

    localparam int ID_W    = 32;              // window id
    localparam int PT_W    = 17;              // doubled centre coordinate
    localparam int SCR_W   = 15;              // screen size in pixels
    localparam int D_W     = PT_W + 2;        // displacement incl. wrap offset
    localparam int MOP_W   = D_W + 1;         // multiplier operand, signed
    localparam int PROD_W  = 2 * MOP_W;       // multiplier product
    localparam int DEN_W   = 2 * D_W - 1;     // squared length, unsigned
    localparam int LO_W    = D_W;             // low slice of a length operand
    localparam int HI_W    = DEN_W - LO_W;    // high slice of a length operand
    localparam int ACC_W   = D_W + DEN_W + 2; // cross product accumulator
    localparam int ADDR_W  = 5;               // APB byte address
    localparam int DATA_W  = 32;              // APB data
    localparam int IN_TD_W = 72;              // input tdata, padded to bytes

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic [2:0] REG_WRAP      = 3'd1;
    localparam logic [2:0] REG_SCR_W     = 3'd2;
    localparam logic [2:0] REG_SCR_H     = 3'd3;
    localparam logic [2:0] REG_ACTIVE_X2 = 3'd4;
    localparam logic [2:0] REG_ACTIVE_Y2 = 3'd5;
    localparam logic [2:0] REG_ACTIVE_ID = 3'd6;

    typedef struct packed {
        logic [1:0]       direction;
        logic             wrap_enable;
        logic [SCR_W-1:0] width_px;
        logic [SCR_W-1:0] height_px;
        logic [PT_W-1:0]  active_x2;
        logic [PT_W-1:0]  active_y2;
        logic [ID_W-1:0]  active_id;
    } t_cfg;

    // classified candidate, passed from front to back
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [D_W-1:0]  dx;    // signed
        logic [D_W-1:0]  dy;    // signed
        logic [D_W-1:0]  num;   // signed, component along search direction
        logic            skip;
        logic            zero;
        logic            last;
    } t_entry;

endpackage
`default_nettype wire

// ----- rtl/dns_front.sv -----
// Front end: takes candidate transactions and classifies them
// (displacement, wrap offset, skip and zero flags). Depends on dns_pkg.
`default_nettype none
module dns_front (
    input  wire dns_pkg::t_cfg              i_cfg,
    input  wire                             i_tvalid,
    output logic                            o_tready,
    input  wire  [dns_pkg::IN_TD_W-1:0]     i_tdata,
    input  wire                             i_tlast,
    input  wire                             i_q_ready,
    output logic                            o_push,
    output dns_pkg::t_entry                 o_entry
);

    logic signed [dns_pkg::D_W-1:0] cx, cy, ax, ay, dx0, dy0, comp0;
    logic signed [dns_pkg::D_W-1:0] off_u, offs, dx, dy, num;
    logic                           horiz, neg, back;

    assign cx = {{2{i_tdata[48]}}, i_tdata[48:32]};
    assign cy = {{2{i_tdata[65]}}, i_tdata[65:49]};
    assign ax = {{2{i_cfg.active_x2[dns_pkg::PT_W-1]}}, i_cfg.active_x2};
    assign ay = {{2{i_cfg.active_y2[dns_pkg::PT_W-1]}}, i_cfg.active_y2};

    assign horiz = ~i_cfg.direction[1];
    assign neg   = ~i_cfg.direction[0];

    assign dx0   = cx - ax;
    assign dy0   = cy - ay;
    assign comp0 = horiz ? dx0 : dy0;
    // behind the search direction
    assign back  = neg ? (comp0 > 0) : (comp0 < 0);

    assign off_u = horiz ? {3'b000, i_cfg.width_px, 1'b0}
                         : {3'b000, i_cfg.height_px, 1'b0};
    assign offs  = neg ? -off_u : off_u;

    assign dx  = (back && i_cfg.wrap_enable && horiz)  ? dx0 + offs : dx0;
    assign dy  = (back && i_cfg.wrap_enable && !horiz) ? dy0 + offs : dy0;
    assign num = neg ? -(horiz ? dx : dy) : (horiz ? dx : dy);

    assign o_tready = i_q_ready;
    assign o_push   = i_tvalid && i_q_ready;

    always_comb begin
        o_entry.id   = i_tdata[dns_pkg::ID_W-1:0];
        o_entry.dx   = dx;
        o_entry.dy   = dy;
        o_entry.num  = num;
        o_entry.skip = back && !i_cfg.wrap_enable;
        o_entry.zero = (dx == '0) && (dy == '0);
        o_entry.last = i_tlast;
    end

endmodule
`default_nettype wire

// ----- rtl/dns_queue.sv -----
// Two-entry queue of classified candidates between front and back.
// Depends on dns_pkg for the entry type.
`default_nettype none
module dns_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire dns_pkg::t_entry i_entry,
    input  wire                  i_pop,
    output dns_pkg::t_entry      o_head,
    output logic                 o_not_empty,
    output logic                 o_not_full
);

    dns_pkg::t_entry r_mem [2];
    logic            r_wr_ptr, r_rd_ptr;
    logic [1:0]      r_count;

    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != 2'd0);
    assign o_not_full  = (r_count != 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/dns_back.sv -----
// Back end: scores classified candidates with one shared multiplier,
// keeps the best choice and emits the result on the last one. Uses dns_pkg.
`default_nettype none
module dns_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire dns_pkg::t_cfg          i_cfg,
    input  wire dns_pkg::t_entry        i_q_head,
    input  wire                         i_q_valid,
    output logic                        o_q_pop,
    output logic                        o_tvalid,
    input  wire                         i_tready,
    output logic [dns_pkg::ID_W-1:0]    o_chosen_id,
    output logic                        o_moved
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVAL = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_C1   = 4'd4;
    localparam logic [3:0] S_C2   = 4'd5;
    localparam logic [3:0] S_C3   = 4'd6;
    localparam logic [3:0] S_C4   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]                         r_state, n_state;
    dns_pkg::t_entry                    r_ent;
    logic signed [dns_pkg::PROD_W-1:0]  r_prod;
    logic [dns_pkg::DEN_W-1:0]          r_den;
    logic signed [dns_pkg::ACC_W-1:0]   r_acc_l, r_acc_r;
    logic [dns_pkg::ID_W-1:0]           r_best_id, r_tie_id;
    logic [dns_pkg::D_W-1:0]            r_best_num;
    logic [dns_pkg::DEN_W-1:0]          r_best_den;
    logic                               r_best_valid, r_tie_valid;
    logic                               r_out_valid;
    logic [dns_pkg::ID_W-1:0]           r_out_id;
    logic                               r_out_moved;

    logic signed [dns_pkg::MOP_W-1:0]   mul_a, mul_b;
    logic signed [dns_pkg::ACC_W-1:0]   prod_ext, prod_sh;
    logic [dns_pkg::DEN_W-1:0]          den_new;
    logic [dns_pkg::ID_W-1:0]           chosen;
    logic                               fin_ok, tie_win;

    assign prod_ext = {{(dns_pkg::ACC_W - dns_pkg::PROD_W){r_prod[dns_pkg::PROD_W-1]}},
                       r_prod};
    assign prod_sh  = prod_ext <<< dns_pkg::LO_W;
    assign den_new  = r_den + r_prod[dns_pkg::DEN_W-1:0];
    assign chosen   = (r_best_valid || r_tie_valid) ? r_best_id : i_cfg.active_id;
    assign fin_ok   = !r_out_valid || i_tready;

    // next higher id for right/down, next lower for left/up
    always_comb begin
        if (i_cfg.direction[0]) begin
            tie_win = (r_ent.id > i_cfg.active_id) && (!r_tie_valid || r_ent.id < r_tie_id);
        end else begin
            tie_win = (r_ent.id < i_cfg.active_id) && (!r_tie_valid || r_ent.id > r_tie_id);
        end
    end

    // multiplier operand select; the product is registered in r_prod
    always_comb begin
        case (r_state)
            S_EVAL: begin
                mul_a = {r_ent.dx[dns_pkg::D_W-1], r_ent.dx};
                mul_b = {r_ent.dx[dns_pkg::D_W-1], r_ent.dx};
            end
            S_SQY: begin
                mul_a = {r_ent.dy[dns_pkg::D_W-1], r_ent.dy};
                mul_b = {r_ent.dy[dns_pkg::D_W-1], r_ent.dy};
            end
            S_SUM: begin
                mul_a = {r_ent.num[dns_pkg::D_W-1], r_ent.num};
                mul_b = {1'b0, r_best_den[dns_pkg::LO_W-1:0]};
            end
            S_C1: begin
                mul_a = {r_ent.num[dns_pkg::D_W-1], r_ent.num};
                mul_b = {{(dns_pkg::MOP_W - dns_pkg::HI_W){1'b0}},
                         r_best_den[dns_pkg::DEN_W-1:dns_pkg::LO_W]};
            end
            S_C2: begin
                mul_a = {r_best_num[dns_pkg::D_W-1], r_best_num};
                mul_b = {1'b0, r_den[dns_pkg::LO_W-1:0]};
            end
            S_C3: begin
                mul_a = {r_best_num[dns_pkg::D_W-1], r_best_num};
                mul_b = {{(dns_pkg::MOP_W - dns_pkg::HI_W){1'b0}},
                         r_den[dns_pkg::DEN_W-1:dns_pkg::LO_W]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_q_valid ? S_EVAL : S_IDLE;
            S_EVAL:  n_state = (r_ent.skip || r_ent.zero || r_tie_valid) ? S_FIN : S_SQY;
            S_SQY:   n_state = S_SUM;
            S_SUM:   n_state = r_best_valid ? S_C1 : S_FIN;
            S_C1:    n_state = S_C2;
            S_C2:    n_state = S_C3;
            S_C3:    n_state = S_C4;
            S_C4:    n_state = S_FIN;
            S_FIN:   n_state = (r_ent.last && !fin_ok) ? S_FIN : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_best_valid <= 1'b0;
            r_tie_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // a result loaded in S_FIN takes over the handed-off one
            if (r_out_valid && i_tready && !(r_state == S_FIN && r_ent.last)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ent <= i_q_head;
                    end
                end
                S_EVAL: begin
                    if (!r_ent.skip && r_ent.zero && r_ent.id != i_cfg.active_id && tie_win) begin
                        r_best_id    <= r_ent.id;
                        r_tie_id     <= r_ent.id;
                        r_tie_valid  <= 1'b1;
                        r_best_valid <= 1'b1;
                    end
                end
                S_SQY: begin
                    r_den <= r_prod[dns_pkg::DEN_W-1:0];
                end
                S_SUM: begin
                    r_den <= den_new;
                    // any score beats no score
                    if (!r_best_valid) begin
                        r_best_id    <= r_ent.id;
                        r_best_num   <= r_ent.num;
                        r_best_den   <= den_new;
                        r_best_valid <= 1'b1;
                    end
                end
                S_C1: begin
                    r_acc_l <= prod_ext;
                end
                S_C2: begin
                    r_acc_l <= r_acc_l + prod_sh;
                end
                S_C3: begin
                    r_acc_r <= prod_ext;
                end
                S_C4: begin
                    // num * best_den > best_num * den, strictly
                    if (r_acc_l > r_acc_r + prod_sh) begin
                        r_best_id  <= r_ent.id;
                        r_best_num <= r_ent.num;
                        r_best_den <= r_den;
                    end
                end
                S_FIN: begin
                    if (r_ent.last && fin_ok) begin
                        r_out_valid  <= 1'b1;
                        r_out_id     <= chosen;
                        r_out_moved  <= (chosen != i_cfg.active_id);
                        r_best_valid <= 1'b0;
                        r_tie_valid  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tvalid    = r_out_valid;
    assign o_chosen_id = r_out_id;
    assign o_moved     = r_out_moved;

endmodule
`default_nettype wire

// ----- rtl/directional_nearest_select.sv -----
// Top level: APB register file, front classifier, queue and scoring back end.
// Each queue head passes S_IDLE, S_EVAL and S_FIN if skipped, zero or after a tie,
// adds S_SQY and S_SUM if first scored, and S_C1 to S_C4 for a cross-multiplied
// compare. A new candidate is taken only after S_FIN, as the shared multiplier
// sequence (two squares, four partial cross products) handles one candidate at a time.
// Reset (synchronous, active low): registers to defaults, queue empty, search re-armed.
`default_nettype none
module directional_nearest_select (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // tdata: cand_id[31:0], cand_x2[48:32], cand_y2[65:49], zero pad
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire  [dns_pkg::IN_TD_W-1:0]  i_s_axis_tdata,
    input  wire                          i_s_axis_tlast,
    // tdata: chosen_id[31:0]
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    output logic [dns_pkg::ID_W-1:0]     o_m_axis_tdata,
    // tuser: moved[0]
    output logic                         o_m_axis_tuser,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [dns_pkg::ADDR_W-1:0]   paddr,
    input  wire  [dns_pkg::DATA_W-1:0]   pwdata,
    output logic [dns_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    dns_pkg::t_cfg   r_cfg;
    dns_pkg::t_entry front_entry, q_head;
    logic            front_push, q_pop, q_not_empty, q_not_full;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction     <= 2'd1;
            r_cfg.wrap_enable   <= 1'b0;
            r_cfg.width_px      <= 15'd1920;
            r_cfg.height_px     <= 15'd1080;
            r_cfg.active_x2     <= '0;
            r_cfg.active_y2     <= '0;
            r_cfg.active_id     <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                dns_pkg::REG_DIRECTION: r_cfg.direction     <= pwdata[1:0];
                dns_pkg::REG_WRAP:      r_cfg.wrap_enable   <= pwdata[0];
                dns_pkg::REG_SCR_W:     r_cfg.width_px      <= pwdata[dns_pkg::SCR_W-1:0];
                dns_pkg::REG_SCR_H:     r_cfg.height_px     <= pwdata[dns_pkg::SCR_W-1:0];
                dns_pkg::REG_ACTIVE_X2: r_cfg.active_x2     <= pwdata[dns_pkg::PT_W-1:0];
                dns_pkg::REG_ACTIVE_Y2: r_cfg.active_y2     <= pwdata[dns_pkg::PT_W-1:0];
                dns_pkg::REG_ACTIVE_ID: r_cfg.active_id     <= pwdata[dns_pkg::ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            dns_pkg::REG_DIRECTION: prdata = {30'd0, r_cfg.direction};
            dns_pkg::REG_WRAP:      prdata = {31'd0, r_cfg.wrap_enable};
            dns_pkg::REG_SCR_W:     prdata = {17'd0, r_cfg.width_px};
            dns_pkg::REG_SCR_H:     prdata = {17'd0, r_cfg.height_px};
            dns_pkg::REG_ACTIVE_X2: prdata = {{15{r_cfg.active_x2[dns_pkg::PT_W-1]}},
                                              r_cfg.active_x2};
            dns_pkg::REG_ACTIVE_Y2: prdata = {{15{r_cfg.active_y2[dns_pkg::PT_W-1]}},
                                              r_cfg.active_y2};
            dns_pkg::REG_ACTIVE_ID: prdata = r_cfg.active_id;
            default:                prdata = '0;
        endcase
    end

    dns_front u_front (
        .i_cfg     (r_cfg),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_tlast   (i_s_axis_tlast),
        .i_q_ready (q_not_full),
        .o_push    (front_push),
        .o_entry   (front_entry)
    );

    dns_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_entry     (front_entry),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_not_empty (q_not_empty),
        .o_not_full  (q_not_full)
    );

    dns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_head    (q_head),
        .i_q_valid   (q_not_empty),
        .o_q_pop     (q_pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_chosen_id (o_m_axis_tdata),
        .o_moved     (o_m_axis_tuser)
    );

endmodule
`default_nettype wire
